@@ hw/rtl/kabf_pkg.sv @@
// ----------------------------------------------------------------------------
// kabf_pkg
// shared constants, register codes and state types of the angle/bias filter
// ----------------------------------------------------------------------------
`default_nettype none

package kabf_pkg;

  localparam int NUM_AXES_DEF    = 2;
  localparam int VALUE_WIDTH_DEF = 32;
  localparam int COV_FRAC        = 24;
  localparam int CFG_W           = 25;
  localparam int CFG_IDX_W       = 2;
  localparam int SAMPLE_W        = 32;

  localparam logic [CFG_W-1:0] STEP_TIME_RST     = 25'd167772;
  localparam logic [CFG_W-1:0] ANGLE_NOISE_RST   = 25'd167772;
  localparam logic [CFG_W-1:0] BIAS_NOISE_RST    = 25'd5033;
  localparam logic [CFG_W-1:0] MEASURE_NOISE_RST = 25'd167772;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_STEP_TIME,
    REG_ANGLE_NOISE,
    REG_BIAS_NOISE,
    REG_MEASURE_NOISE
  } cfg_reg_e;

  typedef enum logic [1:0] {
    UNIT_IDLE,
    UNIT_RUN,
    UNIT_FIN
  } unit_state_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_MUL_GO,
    ST_MUL_WAIT,
    ST_YS,
    ST_DIV_GO,
    ST_DIV_WAIT,
    ST_DONE
  } core_state_e;

  typedef enum logic [3:0] {
    M_EA_PRED,
    M_T1,
    M_AA_PRED,
    M_T2,
    M_BB_PRED,
    M_EA_COR,
    M_EB_COR,
    M_AA_COR,
    M_AB_COR,
    M_BA_COR,
    M_BB_COR
  } mul_step_e;

endpackage

`default_nettype wire

@@ hw/rtl/kabf_state_mem.sv @@
// ----------------------------------------------------------------------------
// kabf_state_mem
// per-axis filter state memory, registered read, entries read as zero
// until first written
// ----------------------------------------------------------------------------
`default_nettype none

module kabf_state_mem
  import kabf_pkg::*;
#(
  parameter int NUM_AXES = NUM_AXES_DEF,
  parameter int VW       = VALUE_WIDTH_DEF
) (
  input  wire logic                                              clk_i,
  input  wire logic                                              rst_ni,
  input  wire logic                                              rd_en_i,
  input  wire logic [$clog2((NUM_AXES > 1) ? NUM_AXES : 2)-1:0]  rd_addr_i,
  output logic      [6*VW-1:0]                                   rd_data_o,
  input  wire logic                                              wr_en_i,
  input  wire logic [$clog2((NUM_AXES > 1) ? NUM_AXES : 2)-1:0]  wr_addr_i,
  input  wire logic [6*VW-1:0]                                   wr_data_i
);

  logic [6*VW-1:0]     mem_q [NUM_AXES];
  logic [NUM_AXES-1:0] vld_q;
  logic [6*VW-1:0]     data_q;
  logic                data_vld_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      data_q <= mem_q[rd_addr_i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q      <= '0;
      data_vld_q <= 1'b0;
    end else begin
      if (wr_en_i) begin
        vld_q[wr_addr_i] <= 1'b1;
      end
      if (rd_en_i) begin
        data_vld_q <= vld_q[rd_addr_i];
      end
    end
  end

  assign rd_data_o = data_vld_q ? data_q : '0;

endmodule

`default_nettype wire

@@ hw/rtl/kabf_mul.sv @@
// ----------------------------------------------------------------------------
// kabf_mul
// shared fixed-point multiplier: 16-bit slices per cycle, product shifted
// right by the covariance fraction, rounded on magnitude and saturated
// ----------------------------------------------------------------------------
`default_nettype none

module kabf_mul
  import kabf_pkg::*;
#(
  parameter int VW = VALUE_WIDTH_DEF,
  parameter int OW = 32
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 start_i,
  input  wire logic signed [OW-1:0] a_i,
  input  wire logic signed [OW-1:0] b_i,
  output logic                      done_o,
  output logic signed [VW-1:0]      p_o
);

  localparam int NCH = (OW + 15) / 16;
  localparam int BW  = NCH * 16;
  localparam int AW  = OW + BW;
  localparam int SHW = AW + 1 - COV_FRAC;
  localparam int CW  = $clog2(NCH + 1);

  unit_state_e           state_q, state_d;
  logic [OW-1:0]         ua_q, ua_d;
  logic [BW-1:0]         ub_q, ub_d;
  logic [AW-1:0]         acc_q, acc_d;
  logic [CW-1:0]         cnt_q, cnt_d;
  logic                  neg_q, neg_d;
  logic signed [VW-1:0]  p_q, p_d;
  logic                  done_q, done_d;

  logic [AW-1:0]  prod;
  logic [AW:0]    rnd;
  logic [SHW-1:0] sh;
  logic [SHW-1:0] lim;
  logic [VW-1:0]  m;
  logic [OW-1:0]  mag_b;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= UNIT_IDLE;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ua_q  <= ua_d;
    ub_q  <= ub_d;
    acc_q <= acc_d;
    cnt_q <= cnt_d;
    neg_q <= neg_d;
    p_q   <= p_d;
  end

  always_comb begin
    state_d = state_q;
    ua_d    = ua_q;
    ub_d    = ub_q;
    acc_d   = acc_q;
    cnt_d   = cnt_q;
    neg_d   = neg_q;
    p_d     = p_q;
    done_d  = 1'b0;

    mag_b = b_i[OW-1] ? OW'(-b_i) : OW'(b_i);
    prod  = AW'(ua_q) * AW'(ub_q[BW-1 -: 16]);
    rnd   = {1'b0, acc_q} + ((AW+1)'(1) << (COV_FRAC - 1));
    sh    = rnd[AW:COV_FRAC];
    lim   = neg_q ? (SHW'(1) << (VW - 1)) : ((SHW'(1) << (VW - 1)) - SHW'(1));
    m     = (sh > lim) ? lim[VW-1:0] : sh[VW-1:0];

    case (state_q)
      UNIT_IDLE: begin
        if (start_i) begin
          ua_d    = a_i[OW-1] ? OW'(-a_i) : OW'(a_i);
          ub_d    = BW'(mag_b);
          neg_d   = a_i[OW-1] ^ b_i[OW-1];
          acc_d   = '0;
          cnt_d   = CW'(NCH);
          state_d = UNIT_RUN;
        end
      end
      UNIT_RUN: begin
        acc_d = (acc_q << 16) + prod;
        ub_d  = ub_q << 16;
        cnt_d = cnt_q - CW'(1);
        if (cnt_q == CW'(1)) begin
          state_d = UNIT_FIN;
        end
      end
      UNIT_FIN: begin
        p_d     = neg_q ? (VW'(0) - m) : m;
        done_d  = 1'b1;
        state_d = UNIT_IDLE;
      end
      default: begin
        state_d = UNIT_IDLE;
      end
    endcase
  end

  assign done_o = done_q;
  assign p_o    = p_q;

endmodule

`default_nettype wire

@@ hw/rtl/kabf_div.sv @@
// ----------------------------------------------------------------------------
// kabf_div
// gain divider: restoring division one quotient bit per cycle, quotient in
// covariance format truncated toward zero and saturated
// ----------------------------------------------------------------------------
`default_nettype none

module kabf_div
  import kabf_pkg::*;
#(
  parameter int VW = VALUE_WIDTH_DEF
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 start_i,
  input  wire logic signed [VW-1:0] p_i,
  input  wire logic signed [VW-1:0] s_i,
  output logic                      done_o,
  output logic signed [VW-1:0]      q_o
);

  localparam int NW = VW + COV_FRAC;
  localparam int CW = $clog2(NW + 1);

  unit_state_e          state_q, state_d;
  logic [NW-1:0]        num_q, num_d;
  logic [VW:0]          rem_q, rem_d;
  logic [VW-1:0]        us_q, us_d;
  logic [CW-1:0]        cnt_q, cnt_d;
  logic                 neg_q, neg_d;
  logic                 pz_q, pz_d;
  logic signed [VW-1:0] q_q, q_d;
  logic                 done_q, done_d;

  logic [VW-1:0] up;
  logic [VW:0]   rem_t;
  logic          ge;
  logic [NW-1:0] lim;
  logic [VW-1:0] m;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= UNIT_IDLE;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q <= num_d;
    rem_q <= rem_d;
    us_q  <= us_d;
    cnt_q <= cnt_d;
    neg_q <= neg_d;
    pz_q  <= pz_d;
    q_q   <= q_d;
  end

  always_comb begin
    state_d = state_q;
    num_d   = num_q;
    rem_d   = rem_q;
    us_d    = us_q;
    cnt_d   = cnt_q;
    neg_d   = neg_q;
    pz_d    = pz_q;
    q_d     = q_q;
    done_d  = 1'b0;

    up    = p_i[VW-1] ? VW'(-p_i) : VW'(p_i);
    rem_t = {rem_q[VW-1:0], num_q[NW-1]};
    ge    = (rem_t >= {1'b0, us_q});
    lim   = neg_q ? (NW'(1) << (VW - 1)) : ((NW'(1) << (VW - 1)) - NW'(1));
    m     = (num_q > lim) ? lim[VW-1:0] : num_q[VW-1:0];

    case (state_q)
      UNIT_IDLE: begin
        if (start_i) begin
          num_d   = {up, {COV_FRAC{1'b0}}};
          us_d    = s_i[VW-1] ? VW'(-s_i) : VW'(s_i);
          rem_d   = '0;
          neg_d   = p_i[VW-1] ^ s_i[VW-1];
          pz_d    = (p_i == '0);
          cnt_d   = CW'(NW);
          state_d = UNIT_RUN;
        end
      end
      UNIT_RUN: begin
        rem_d = ge ? (rem_t - {1'b0, us_q}) : rem_t;
        num_d = {num_q[NW-2:0], ge};
        cnt_d = cnt_q - CW'(1);
        if (cnt_q == CW'(1)) begin
          state_d = UNIT_FIN;
        end
      end
      UNIT_FIN: begin
        // zero divisor ends with an all-ones quotient, which clamps with the sign; a zero dividend gives zero
        q_d     = pz_q ? '0 : (neg_q ? (VW'(0) - m) : m);
        done_d  = 1'b1;
        state_d = UNIT_IDLE;
      end
      default: begin
        state_d = UNIT_IDLE;
      end
    endcase
  end

  assign done_o = done_q;
  assign q_o    = q_q;

endmodule

`default_nettype wire

@@ hw/rtl/kalman_angle_bias_filter_core.sv @@
// ----------------------------------------------------------------------------
// kalman_angle_bias_filter_core
// two-state tilt filter per axis: predict, gain division, correct; state kept
// in a per-axis memory and updated by a sequencer around one shared multiplier
// one item in flight: in_ready is high only when idle, so the next beat can be
// taken in the cycle after the result is posted, and an output stall that holds
// the result in the done state holds the next beat back as well; the work runs
// through the 16-bit slice multiplier and the bit-serial gain dividers
// reset: registers take their default values and every axis state reads as zero
// ----------------------------------------------------------------------------
`default_nettype none

module kalman_angle_bias_filter_core
  import kabf_pkg::*;
#(
  parameter int NUM_AXES    = NUM_AXES_DEF,
  parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]       cfg_idx_i,
  input  wire logic [CFG_W-1:0]           cfg_wdata_i,
  input  wire logic                       in_valid_i,
  output logic                            in_ready_o,
  input  wire logic                       axis_i,
  input  wire logic signed [SAMPLE_W-1:0] accel_angle_i,
  input  wire logic signed [SAMPLE_W-1:0] gyro_rate_i,
  output logic                            out_valid_o,
  input  wire logic                       out_ready_i,
  output logic                            axis_out_o,
  output logic signed [SAMPLE_W-1:0]      filtered_angle_o
);

  localparam int W   = VALUE_WIDTH;
  localparam int OW  = (W > 26) ? W : 26;
  localparam int SW  = ((W > SAMPLE_W) ? W : SAMPLE_W) + 4;
  localparam int AXW = (NUM_AXES > 1) ? $clog2(NUM_AXES) : 1;

  localparam logic signed [SW-1:0] VMAX_S = {{(SW-W+1){1'b0}}, {(W-1){1'b1}}};
  localparam logic signed [SW-1:0] VMIN_S = ~VMAX_S;
  localparam logic signed [SW-1:0] OMAX_S = {{(SW-SAMPLE_W+1){1'b0}}, {(SAMPLE_W-1){1'b1}}};
  localparam logic signed [SW-1:0] OMIN_S = ~OMAX_S;

  function automatic logic signed [W-1:0] sat_w(input logic signed [SW-1:0] v);
    if (v > VMAX_S) begin
      sat_w = VMAX_S[W-1:0];
    end else if (v < VMIN_S) begin
      sat_w = VMIN_S[W-1:0];
    end else begin
      sat_w = v[W-1:0];
    end
  endfunction

  function automatic logic signed [SAMPLE_W-1:0] sat_o(input logic signed [W-1:0] v);
    logic signed [SW-1:0] x;
    x = SW'(v);
    if (x > OMAX_S) begin
      sat_o = OMAX_S[SAMPLE_W-1:0];
    end else if (x < OMIN_S) begin
      sat_o = OMIN_S[SAMPLE_W-1:0];
    end else begin
      sat_o = x[SAMPLE_W-1:0];
    end
  endfunction

  function automatic logic signed [SW-1:0] ext(input logic signed [W-1:0] v);
    ext = SW'(v);
  endfunction

  function automatic logic signed [SW-1:0] rext(input logic [CFG_W-1:0] v);
    rext = $signed(SW'(v));
  endfunction

  function automatic logic signed [OW-1:0] opw(input logic signed [W-1:0] v);
    opw = OW'(v);
  endfunction

  function automatic logic signed [OW-1:0] opr(input logic [CFG_W-1:0] v);
    opr = $signed(OW'(v));
  endfunction

  // configuration registers
  logic [CFG_W-1:0] dt_q, an_q, bn_q, mn_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dt_q <= STEP_TIME_RST;
      an_q <= ANGLE_NOISE_RST;
      bn_q <= BIAS_NOISE_RST;
      mn_q <= MEASURE_NOISE_RST;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_idx_i))
        REG_STEP_TIME:     dt_q <= cfg_wdata_i;
        REG_ANGLE_NOISE:   an_q <= cfg_wdata_i;
        REG_BIAS_NOISE:    bn_q <= cfg_wdata_i;
        REG_MEASURE_NOISE: mn_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  core_state_e state_q, state_d;
  mul_step_e   mstep_q, mstep_d;
  logic        out_valid_q, out_valid_d;
  logic        oob_q, oob_d;

  logic                       axis_q, axis_d;
  logic signed [W-1:0]        meas_q, meas_d;
  logic signed [W-1:0]        rate_q, rate_d;
  logic signed [W-1:0]        ea_q, ea_d, eb_q, eb_d;
  logic signed [W-1:0]        aa_q, aa_d, ab_q, ab_d, ba_q, ba_d, bb_q, bb_d;
  logic signed [W-1:0]        t_q, t_d, y_q, y_d, s_q, s_d, k0_q, k0_d, k1_q, k1_d;
  logic                       axis_out_q, axis_out_d;
  logic signed [SAMPLE_W-1:0] fa_q, fa_d;

  logic                 accept, oob_in;
  logic                 rd_en, wr_en;
  logic [6*W-1:0]       rd_data, wr_data;
  logic                 mul_start, mul_done;
  logic signed [OW-1:0] mul_a, mul_b;
  logic signed [W-1:0]  mul_p;
  logic                 div_start, div0_done, div1_done;
  logic signed [W-1:0]  div0_q, div1_q;

  assign in_ready_o = (state_q == ST_IDLE);
  assign accept     = in_valid_i & in_ready_o;
  assign oob_in     = (int'(axis_i) >= NUM_AXES);
  assign rd_en      = accept & ~oob_in;
  assign wr_data    = {ea_q, eb_q, aa_q, ab_q, ba_q, bb_q};

  kabf_state_mem #(
    .NUM_AXES (NUM_AXES),
    .VW       (W)
  ) u_mem (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_en_i   (rd_en),
    .rd_addr_i (AXW'(axis_i)),
    .rd_data_o (rd_data),
    .wr_en_i   (wr_en),
    .wr_addr_i (AXW'(axis_q)),
    .wr_data_i (wr_data)
  );

  kabf_mul #(
    .VW (W),
    .OW (OW)
  ) u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_start),
    .a_i     (mul_a),
    .b_i     (mul_b),
    .done_o  (mul_done),
    .p_o     (mul_p)
  );

  kabf_div #(
    .VW (W)
  ) u_div0 (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .p_i     (aa_q),
    .s_i     (s_q),
    .done_o  (div0_done),
    .q_o     (div0_q)
  );

  kabf_div #(
    .VW (W)
  ) u_div1 (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .p_i     (ba_q),
    .s_i     (s_q),
    .done_o  (div1_done),
    .q_o     (div1_q)
  );

  // multiplier operand select
  always_comb begin
    mul_a = opr(dt_q);
    mul_b = opr(dt_q);
    case (mstep_q)
      M_EA_PRED: begin
        mul_a = opr(dt_q);
        mul_b = opw(sat_w(ext(rate_q) - ext(eb_q)));
      end
      M_T1: begin
        mul_a = opr(dt_q);
        mul_b = opw(sat_w(ext(ba_q) + ext(ab_q)));
      end
      M_AA_PRED: begin
        mul_a = opr(an_q);
        mul_b = opr(dt_q);
      end
      M_T2: begin
        mul_a = opr(dt_q);
        mul_b = opw(bb_q);
      end
      M_BB_PRED: begin
        mul_a = opr(bn_q);
        mul_b = opr(dt_q);
      end
      M_EA_COR: begin
        mul_a = opw(k0_q);
        mul_b = opw(y_q);
      end
      M_EB_COR: begin
        mul_a = opw(k1_q);
        mul_b = opw(y_q);
      end
      M_AA_COR: begin
        mul_a = opw(k0_q);
        mul_b = opw(aa_q);
      end
      M_AB_COR: begin
        mul_a = opw(k0_q);
        mul_b = opw(ab_q);
      end
      M_BA_COR: begin
        mul_a = opw(k1_q);
        mul_b = opw(aa_q);
      end
      M_BB_COR: begin
        mul_a = opw(k1_q);
        mul_b = opw(ab_q);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      mstep_q     <= M_EA_PRED;
      out_valid_q <= 1'b0;
      oob_q       <= 1'b0;
    end else begin
      state_q     <= state_d;
      mstep_q     <= mstep_d;
      out_valid_q <= out_valid_d;
      oob_q       <= oob_d;
    end
  end

  always_ff @(posedge clk_i) begin
    axis_q     <= axis_d;
    meas_q     <= meas_d;
    rate_q     <= rate_d;
    ea_q       <= ea_d;
    eb_q       <= eb_d;
    aa_q       <= aa_d;
    ab_q       <= ab_d;
    ba_q       <= ba_d;
    bb_q       <= bb_d;
    t_q        <= t_d;
    y_q        <= y_d;
    s_q        <= s_d;
    k0_q       <= k0_d;
    k1_q       <= k1_d;
    axis_out_q <= axis_out_d;
    fa_q       <= fa_d;
  end

  always_comb begin
    state_d     = state_q;
    mstep_d     = mstep_q;
    oob_d       = oob_q;
    axis_d      = axis_q;
    meas_d      = meas_q;
    rate_d      = rate_q;
    ea_d        = ea_q;
    eb_d        = eb_q;
    aa_d        = aa_q;
    ab_d        = ab_q;
    ba_d        = ba_q;
    bb_d        = bb_q;
    t_d         = t_q;
    y_d         = y_q;
    s_d         = s_q;
    k0_d        = k0_q;
    k1_d        = k1_q;
    axis_out_d  = axis_out_q;
    fa_d        = fa_q;
    out_valid_d = out_valid_q & ~out_ready_i;
    mul_start   = 1'b0;
    div_start   = 1'b0;
    wr_en       = 1'b0;

    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          axis_d  = axis_i;
          meas_d  = sat_w(SW'(accel_angle_i));
          rate_d  = sat_w(SW'(gyro_rate_i));
          oob_d   = oob_in;
          state_d = oob_in ? ST_DONE : ST_LOAD;
        end
      end
      ST_LOAD: begin
        ea_d    = rd_data[6*W-1 -: W];
        eb_d    = rd_data[5*W-1 -: W];
        aa_d    = rd_data[4*W-1 -: W];
        ab_d    = rd_data[3*W-1 -: W];
        ba_d    = rd_data[2*W-1 -: W];
        bb_d    = rd_data[W-1:0];
        mstep_d = M_EA_PRED;
        state_d = ST_MUL_GO;
      end
      ST_MUL_GO: begin
        mul_start = 1'b1;
        state_d   = ST_MUL_WAIT;
      end
      ST_MUL_WAIT: begin
        if (mul_done) begin
          mstep_d = mul_step_e'(mstep_q + 4'd1);
          state_d = ST_MUL_GO;
          case (mstep_q)
            M_EA_PRED: ea_d = sat_w(ext(ea_q) + ext(mul_p));
            M_T1:      t_d  = mul_p;
            M_AA_PRED: aa_d = sat_w(ext(aa_q) - ext(t_q) + ext(mul_p));
            M_T2: begin
              ab_d = sat_w(ext(ab_q) - ext(mul_p));
              ba_d = sat_w(ext(ba_q) - ext(mul_p));
            end
            M_BB_PRED: begin
              bb_d    = sat_w(ext(bb_q) + ext(mul_p));
              state_d = ST_YS;
            end
            M_EA_COR:  ea_d = sat_w(ext(ea_q) + ext(mul_p));
            M_EB_COR:  eb_d = sat_w(ext(eb_q) + ext(mul_p));
            M_AA_COR:  aa_d = sat_w(ext(aa_q) - ext(mul_p));
            M_AB_COR:  ab_d = sat_w(ext(ab_q) - ext(mul_p));
            M_BA_COR:  ba_d = sat_w(ext(ba_q) - ext(mul_p));
            M_BB_COR: begin
              bb_d    = sat_w(ext(bb_q) - ext(mul_p));
              state_d = ST_DONE;
            end
            default: state_d = ST_DONE;
          endcase
        end
      end
      ST_YS: begin
        y_d     = sat_w(ext(meas_q) - ext(ea_q));
        s_d     = sat_w(ext(aa_q) + rext(mn_q));
        state_d = ST_DIV_GO;
      end
      ST_DIV_GO: begin
        div_start = 1'b1;
        state_d   = ST_DIV_WAIT;
      end
      ST_DIV_WAIT: begin
        if (div0_done & div1_done) begin
          k0_d    = div0_q;
          k1_d    = div1_q;
          mstep_d = M_EA_COR;
          state_d = ST_MUL_GO;
        end
      end
      ST_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          wr_en       = ~oob_q;
          axis_out_d  = axis_q;
          fa_d        = oob_q ? '0 : sat_o(ea_q);
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign out_valid_o      = out_valid_q;
  assign axis_out_o       = axis_out_q;
  assign filtered_angle_o = fa_q;

endmodule

`default_nettype wire

@@ tb/sv/tb_kalman_angle_bias_filter_core.sv @@
// ----------------------------------------------------------------------------
// tb_kalman_angle_bias_filter_core
// Drives accelerometer/gyro beats into the two-axis angle/bias filter with
// random gaps and output stalls. It keeps its own fixed-point copy of the
// per-axis filter state to predict every filtered angle, and compares each
// output beat in order. Register settings change between phases, only while
// the filter is idle.
// ----------------------------------------------------------------------------
module tb_kalman_angle_bias_filter_core;
  import kabf_pkg::*;

  localparam longint VMAX = 64'sd2147483647;
  localparam longint VMIN = -64'sd2147483648;
  localparam int LIMIT = 1000000;

  typedef struct packed {
    logic        axis;
    logic [31:0] accel;
    logic [31:0] gyro;
  } imu_beat_t;

  typedef struct packed {
    logic        axis;
    logic [31:0] angle;
  } angle_beat_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we = 1'b0;
  cfg_reg_e cfg_idx = REG_STEP_TIME;
  logic [CFG_W-1:0] cfg_wdata = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic axis_in = 1'b0;
  logic signed [31:0] accel_in = '0;
  logic signed [31:0] gyro_in = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic axis_out;
  logic signed [31:0] angle_out;

  imu_beat_t   pending_beats[$];
  angle_beat_t expected_angles[$];
  int errors = 0;
  int cycles = 0;
  int in_gap = 0;
  int out_stall = 0;
  bit idling_on = 1'b1;

  longint unsigned dt_q = 167772, qa_q = 167772, qb_q = 5033, r_q = 167772;
  longint ang_st[2], bias_st[2], paa[2], pab[2], pba[2], pbb[2];

  kalman_angle_bias_filter_core dut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .cfg_we_i(cfg_we), .cfg_idx_i(cfg_idx), .cfg_wdata_i(cfg_wdata),
    .in_valid_i(in_valid), .in_ready_o(in_ready),
    .axis_i(axis_in), .accel_angle_i(accel_in), .gyro_rate_i(gyro_in),
    .out_valid_o(out_valid), .out_ready_i(out_ready),
    .axis_out_o(axis_out), .filtered_angle_o(angle_out)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic longint clamp32(longint v);
    if (v > VMAX) return VMAX;
    if (v < VMIN) return VMIN;
    return v;
  endfunction

  function automatic longint signed_mag(longint unsigned m, bit neg);
    longint unsigned lim;
    lim = neg ? 64'd2147483648 : 64'd2147483647;
    if (m > lim) m = lim;
    return neg ? -longint'(m) : longint'(m);
  endfunction

  // q8.24 product, rounded half away from zero on magnitude
  function automatic longint fx_mul(longint a, longint b);
    longint unsigned ma, mb, p;
    ma = a < 0 ? -a : a;
    mb = b < 0 ? -b : b;
    p = (ma * mb + 64'd8388608) >> COV_FRAC;
    return signed_mag(p, (a < 0) != (b < 0));
  endfunction

  function automatic longint fx_gain(longint p, longint s);
    longint unsigned mp, ms;
    if (s == 0) begin
      if (p == 0) return 0;
      return p > 0 ? VMAX : VMIN;
    end
    mp = p < 0 ? -p : p;
    ms = s < 0 ? -s : s;
    return signed_mag((mp << COV_FRAC) / ms, (p < 0) != (s < 0));
  endfunction

  function automatic angle_beat_t filter_step(imu_beat_t b);
    angle_beat_t r;
    longint dt, t, y, s, k0, k1;
    int a;
    a = int'(b.axis);
    dt = longint'(dt_q);
    ang_st[a] = clamp32(ang_st[a] +
                        fx_mul(dt, clamp32(longint'($signed(b.gyro)) - bias_st[a])));
    t = fx_mul(dt, clamp32(pba[a] + pab[a]));
    paa[a] = clamp32(paa[a] - t + fx_mul(longint'(qa_q), dt));
    t = fx_mul(dt, pbb[a]);
    pab[a] = clamp32(pab[a] - t);
    pba[a] = clamp32(pba[a] - t);
    pbb[a] = clamp32(pbb[a] + fx_mul(longint'(qb_q), dt));
    y = clamp32(longint'($signed(b.accel)) - ang_st[a]);
    s = clamp32(paa[a] + longint'(r_q));
    k0 = fx_gain(paa[a], s);
    k1 = fx_gain(pba[a], s);
    ang_st[a] = clamp32(ang_st[a] + fx_mul(k0, y));
    bias_st[a] = clamp32(bias_st[a] + fx_mul(k1, y));
    paa[a] = clamp32(paa[a] - fx_mul(k0, paa[a]));
    pab[a] = clamp32(pab[a] - fx_mul(k0, pab[a]));
    pba[a] = clamp32(pba[a] - fx_mul(k1, paa[a]));
    pbb[a] = clamp32(pbb[a] - fx_mul(k1, pab[a]));
    r.axis = b.axis;
    r.angle = ang_st[a][31:0];
    return r;
  endfunction

  // input driver, predicts on every accepted beat
  always @(posedge clk_i or negedge rst_ni) begin
    imu_beat_t nb;
    if (!rst_ni) begin
      in_valid <= 1'b0;
      in_gap <= 0;
    end else begin
      if (in_valid && in_ready)
        expected_angles.push_back(filter_step({axis_in, accel_in, gyro_in}));
      if (!in_valid || in_ready) begin
        if (in_gap != 0) begin
          in_gap <= in_gap - 1;
          in_valid <= 1'b0;
        end else if (pending_beats.size() != 0) begin
          nb = pending_beats.pop_front();
          axis_in <= nb.axis;
          accel_in <= nb.accel;
          gyro_in <= nb.gyro;
          in_valid <= 1'b1;
          in_gap <= idling_on ? int'($urandom_range(0, 12)) : 0;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // output monitor with random stalls
  always @(posedge clk_i or negedge rst_ni) begin
    angle_beat_t e;
    if (!rst_ni) begin
      out_ready <= 1'b0;
      out_stall <= 0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_angles.size() == 0) begin
          errors++;
          $display("%0t: unexpected beat axis %0d angle %0d", $time, axis_out, angle_out);
        end else begin
          e = expected_angles.pop_front();
          if (e.axis !== axis_out) begin
            errors++;
            $display("%0t: axis expected %0d actual %0d", $time, e.axis, axis_out);
          end
          if (e.angle !== angle_out) begin
            errors++;
            $display("%0t: angle expected %0d actual %0d", $time,
                     $signed(e.angle), angle_out);
          end
        end
        out_stall <= idling_on ? int'($urandom_range(0, 12)) : 0;
        out_ready <= 1'b0;
      end else if (out_stall != 0) begin
        out_stall <= out_stall - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  task automatic wait_idle();
    while (pending_beats.size() != 0 || in_valid || expected_angles.size() != 0)
      @(posedge clk_i);
    repeat (200) @(posedge clk_i);
  endtask

  task automatic write_reg(cfg_reg_e idx, logic [CFG_W-1:0] v);
    @(posedge clk_i);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_wdata <= v;
    case (idx)
      REG_STEP_TIME:   dt_q = 64'(v);
      REG_ANGLE_NOISE: qa_q = 64'(v);
      REG_BIAS_NOISE:  qb_q = 64'(v);
      default:         r_q = 64'(v);
    endcase
    @(posedge clk_i);
    cfg_we <= 1'b0;
  endtask

  task automatic set_regs(logic [CFG_W-1:0] dt, logic [CFG_W-1:0] qa,
                          logic [CFG_W-1:0] qb, logic [CFG_W-1:0] r);
    wait_idle();
    write_reg(REG_STEP_TIME, dt);
    write_reg(REG_ANGLE_NOISE, qa);
    write_reg(REG_BIAS_NOISE, qb);
    write_reg(REG_MEASURE_NOISE, r);
  endtask

  function automatic logic [31:0] rand_sample();
    case ($urandom_range(0, 9))
      0: return $urandom();
      1: return $urandom_range(0, 1) ? 32'h7fffffff : 32'h80000000;
      default: return $urandom_range(0, 11796480) - 5898240;
    endcase
  endfunction

  task automatic push_random(int n);
    imu_beat_t b;
    repeat (n) begin
      b.axis = 1'($urandom_range(0, 1));
      b.accel = rand_sample();
      b.gyro = $urandom_range(0, 3) == 0 ? rand_sample() : $urandom_range(0, 131072) - 65536;
      pending_beats.push_back(b);
    end
  endtask

  function automatic logic [CFG_W-1:0] rand_reg();
    case ($urandom_range(0, 5))
      0: return 25'd16777216;
      1: return CFG_W'($urandom_range(0, 1));
      2: return CFG_W'($urandom());
      default: return CFG_W'($urandom_range(1, 400000));
    endcase
  endfunction

  initial begin
    for (int a = 0; a < 2; a++) begin
      ang_st[a] = 0; bias_st[a] = 0;
      paa[a] = 0; pab[a] = 0; pba[a] = 0; pbb[a] = 0;
    end
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: field extremes on both axes at reset settings
    pending_beats.push_back({1'b0, 32'h00000000, 32'h00000000});
    pending_beats.push_back({1'b1, 32'h7fffffff, 32'h7fffffff});
    pending_beats.push_back({1'b0, 32'h80000000, 32'h80000000});
    pending_beats.push_back({1'b1, 32'h80000000, 32'h7fffffff});
    pending_beats.push_back({1'b0, 32'h7fffffff, 32'h80000000});
    pending_beats.push_back({1'b1, 32'h00010000, 32'hffff0000});
    pending_beats.push_back({1'b0, 32'hffffffff, 32'h00000001});
    // zero noise settings with the smallest nonzero step time
    set_regs(25'd1, 25'd0, 25'd0, 25'd0);
    pending_beats.push_back({1'b0, 32'h00400000, 32'h00010000});
    pending_beats.push_back({1'b1, 32'hffc00000, 32'h7fffffff});
    // settings of 1.0 in q8.24
    set_regs(25'd16777216, 25'd16777216, 25'd16777216, 25'd16777216);
    pending_beats.push_back({1'b0, 32'h7fffffff, 32'h7fffffff});
    pending_beats.push_back({1'b1, 32'h80000000, 32'h80000000});
    pending_beats.push_back({1'b0, 32'h80000000, 32'h7fffffff});
    // full-width register values, used as written
    set_regs(25'h1ffffff, 25'h1ffffff, 25'h1ffffff, 25'h1ffffff);
    pending_beats.push_back({1'b1, 32'h7fffffff, 32'h80000000});
    pending_beats.push_back({1'b0, 32'h12345678, 32'hedcba987});
    // smallest nonzero step time and measurement noise, zero process noise
    set_regs(25'd1, 25'd0, 25'd0, 25'd1);
    pending_beats.push_back({1'b0, 32'h00100000, 32'h00000000});
    pending_beats.push_back({1'b1, 32'hfff00000, 32'h00000000});

    set_regs(25'd167772, 25'd167772, 25'd5033, 25'd167772);
    push_random(150);
    for (int ph = 0; ph < 6; ph++) begin
      set_regs(rand_reg(), rand_reg(), rand_reg(), rand_reg());
      idling_on = (ph % 3) != 1;
      push_random(140);
    end

    wait_idle();
    if (errors == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end

endmodule

@@ filelist.f @@
hw/rtl/kabf_pkg.sv
hw/rtl/kabf_state_mem.sv
hw/rtl/kabf_mul.sv
hw/rtl/kabf_div.sv
hw/rtl/kalman_angle_bias_filter_core.sv
tb/sv/tb_kalman_angle_bias_filter_core.sv
